@@ design/tsmaf_pkg.sv @@
package tsmaf_pkg;

  localparam int DATA_W       = 12;
  localparam int MEDIAN_TAPS  = 5;
  localparam int AVERAGE_TAPS = 4;

  localparam int MPOS_W  = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
  localparam int APOS_W  = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
  localparam int MFILL_W = $clog2(MEDIAN_TAPS + 1);
  localparam int AFILL_W = $clog2(AVERAGE_TAPS + 1);
  localparam int SUM_W   = DATA_W + ((AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1);
  localparam int REM_W   = AFILL_W + 1;

  localparam int CNT_MAX_A = (MEDIAN_TAPS > AVERAGE_TAPS) ? MEDIAN_TAPS : AVERAGE_TAPS;
  localparam int CNT_MAX   = (CNT_MAX_A > SUM_W) ? CNT_MAX_A : SUM_W;
  localparam int CNT_W     = $clog2(CNT_MAX);

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLAMP = 7'b0000010,
    S_RANK  = 7'b0000100,
    S_AVGW  = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic clamp;
    logic rank;
    logic avg_wr;
    logic sum;
    logic div;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rank_last;
    logic sum_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

@@ design/tsmaf_ctrl.sv @@
module tsmaf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_operation,
  output logic            in_stall,
  input  tsmaf_pkg::sts_t sts,
  output tsmaf_pkg::cmd_t cmd
);
  import tsmaf_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (in_operation == OP_RESTART) begin
            cmd.restart = 1'b1;
          end else begin
            state_nxt = S_CLAMP;
          end
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_RANK;
      end
      S_RANK: begin
        cmd.rank = 1'b1;
        if (sts.rank_last) begin
          state_nxt = S_AVGW;
        end
      end
      S_AVGW: begin
        cmd.avg_wr = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (sts.sum_last) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/tsmaf_dp.sv @@
module tsmaf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tsmaf_pkg::DATA_W-1:0] cfg_wr_data,
  input  logic [tsmaf_pkg::DATA_W-1:0] in_sample,
  input  tsmaf_pkg::cmd_t              cmd,
  output tsmaf_pkg::sts_t              sts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tsmaf_pkg::DATA_W-1:0] out_filtered
);
  import tsmaf_pkg::*;

  logic [DATA_W-1:0]  max_jump_r;
  logic [DATA_W-1:0]  sample_r;
  logic [DATA_W-1:0]  last_r;
  logic               seeded_r;
  logic [DATA_W-1:0]  mwin_r [MEDIAN_TAPS];
  logic [MPOS_W-1:0]  mpos_r;
  logic [MFILL_W-1:0] mfill_r;
  logic [DATA_W-1:0]  awin_r [AVERAGE_TAPS];
  logic [APOS_W-1:0]  apos_r;
  logic [AFILL_W-1:0] afill_r;
  logic [DATA_W-1:0]  med_r;
  logic [SUM_W-1:0]   sum_r;
  logic [AFILL_W-1:0] rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_filtered_r;

  logic [DATA_W-1:0]  abs_diff;
  logic [DATA_W-1:0]  clamped;
  logic [DATA_W-1:0]  cand;
  logic [MFILL_W-1:0] rank;
  logic               cand_ok;
  logic [DATA_W-1:0]  aw_sel;
  logic               aw_ok;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   rem_sub;
  logic               q_bit;

  assign abs_diff = (sample_r > last_r) ? (sample_r - last_r) : (last_r - sample_r);
  assign clamped  = (seeded_r && (abs_diff > max_jump_r)) ? last_r : sample_r;

  // stable rank of the candidate among the filled entries
  assign cand    = mwin_r[cnt_r[MPOS_W-1:0]];
  assign cand_ok = ({{MFILL_W{1'b0}}, cnt_r} < {{CNT_W{1'b0}}, mfill_r});
  always_comb begin
    rank = '0;
    for (int j = 0; j < MEDIAN_TAPS; j++) begin
      if ((MFILL_W'(j) < mfill_r) &&
          ((mwin_r[j] < cand) ||
           ((mwin_r[j] == cand) && ({{MFILL_W{1'b0}}, CNT_W'(j)} <
                                    {{MFILL_W{1'b0}}, cnt_r})))) begin
        rank = rank + MFILL_W'(1);
      end
    end
  end

  assign aw_sel = awin_r[cnt_r[APOS_W-1:0]];
  assign aw_ok  = ({{AFILL_W{1'b0}}, cnt_r} < {{CNT_W{1'b0}}, afill_r});

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem_r, sum_r[SUM_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, afill_r});
  assign rem_sub = q_bit ? (rem_sh - {1'b0, afill_r}) : rem_sh;

  assign sts.rank_last = (cnt_r == CNT_W'(MEDIAN_TAPS - 1));
  assign sts.sum_last  = (cnt_r == CNT_W'(AVERAGE_TAPS - 1));
  assign sts.div_last  = (cnt_r == CNT_W'(SUM_W - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_jump_r  <= {DATA_W{1'b1}};
      seeded_r    <= 1'b0;
      mpos_r      <= '0;
      mfill_r     <= '0;
      apos_r      <= '0;
      afill_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_jump_r <= cfg_wr_data;
      end
      if (cmd.restart) begin
        seeded_r <= 1'b0;
        mpos_r   <= '0;
        mfill_r  <= '0;
        apos_r   <= '0;
        afill_r  <= '0;
      end
      if (cmd.clamp) begin
        seeded_r <= 1'b1;
        mpos_r   <= (mpos_r == MPOS_W'(MEDIAN_TAPS - 1)) ? '0 : mpos_r + MPOS_W'(1);
        if (mfill_r != MFILL_W'(MEDIAN_TAPS)) begin
          mfill_r <= mfill_r + MFILL_W'(1);
        end
      end
      if (cmd.avg_wr) begin
        apos_r <= (apos_r == APOS_W'(AVERAGE_TAPS - 1)) ? '0 : apos_r + APOS_W'(1);
        if (afill_r != AFILL_W'(AVERAGE_TAPS)) begin
          afill_r <= afill_r + AFILL_W'(1);
        end
      end
      if (cmd.clamp || cmd.avg_wr || (cmd.rank && sts.rank_last) ||
          (cmd.sum && sts.sum_last) || (cmd.div && sts.div_last)) begin
        cnt_r <= '0;
      end else if (cmd.rank || cmd.sum || cmd.div) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.clamp) begin
      last_r         <= clamped;
      mwin_r[mpos_r] <= clamped;
    end
    if (cmd.rank && cand_ok && (rank == (mfill_r >> 1))) begin
      med_r <= cand;
    end
    if (cmd.avg_wr) begin
      awin_r[apos_r] <= med_r;
      sum_r          <= '0;
      rem_r          <= '0;
    end
    if (cmd.sum && aw_ok) begin
      sum_r <= sum_r + {{(SUM_W - DATA_W){1'b0}}, aw_sel};
    end
    if (cmd.div) begin
      rem_r <= rem_sub[AFILL_W-1:0];
      sum_r <= {sum_r[SUM_W-2:0], q_bit};
    end
    if (cmd.out_load) begin
      out_filtered_r <= sum_r[DATA_W-1:0];
    end
  end

endmodule

@@ design/touch_sample_median_average_filter_core.sv @@
// Touch coordinate filter: jump clamp against the last accepted sample (limit
// max_jump, written on cfg_wr_en), 5-tap median, then 4-tap truncated mean.
// One beat is taken at a time. A sample beat runs through the clamp, 5 rank
// steps over the median window, the average window write, 4 accumulate steps,
// a 14-step bit-serial divide by the fill count and the output load, plus any
// wait on out_stall for an earlier result, before out_valid rises; the next
// beat is taken only after that load. in_stall is low only while idle; a
// restart beat (operation 1) clears the windows and gives no result. The next
// beat may be taken while a result waits.
module touch_sample_median_average_filter_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tsmaf_pkg::DATA_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [tsmaf_pkg::DATA_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tsmaf_pkg::DATA_W-1:0] out_filtered
);
  import tsmaf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tsmaf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  tsmaf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_sample    (in_sample),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered)
  );

endmodule
